// ===== hdl/lobm_pkg.sv =====
// Package for the limit order book matcher: request/result transaction types and codes.
// No dependencies.
package lobm_pkg;

  typedef enum logic [2:0] {
    MODE_ADD_LIMIT = 3'd0,
    MODE_MARKET    = 3'd1,
    MODE_ADD_STOP  = 3'd2,
    MODE_CANCEL    = 3'd3,
    MODE_MATCH     = 3'd4,
    MODE_CHECK     = 3'd5,
    MODE_NONE6     = 3'd6,
    MODE_NONE7     = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;
  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam int unsigned MaxTrades = 63;

  typedef struct packed {
    logic [2:0]  mode;
    logic        side;
    logic [31:0] ord_id;
    logic [15:0] limit_price;
    logic [15:0] stop_price;
    logic [23:0] quantity;
    logic [31:0] stamp;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [15:0] fill_price;
    logic [23:0] fill_qty;
    logic        aggressor;
    logic [1:0]  status;
    logic        last;
  } res_t;

endpackage

// ===== hdl/lobm_front.sv =====
// Front end of the order book matcher: accepts requests and queues them for the engine.
// Depends on lobm_pkg.
module lobm_front import lobm_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  req_t  in_data_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output req_t  q_data_o
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  req_t          mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;
  req_t          cur;

  // Requests with a mode that does nothing are turned into a plain status request here.
  always_comb begin
    cur = in_data_i;
    if (in_data_i.mode == MODE_NONE6 || in_data_i.mode == MODE_NONE7) begin
      cur.mode = MODE_NONE6;
    end
  end

  assign in_ready_o = (cnt_q != (AW+1)'(Depth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop  = q_valid_o && q_ready_i;
  assign q_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (AW+1)'(Depth)) |-> !push) else $error("push while full");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
endmodule

// ===== hdl/lobm_engine.sv =====
// Back end of the order book matcher: book and stop storage, best-price scan, fills.
// Depends on lobm_pkg.
module lobm_engine import lobm_pkg::*; #(
  parameter int BookSlots = 16,
  parameter int StopSlots = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  req_t q_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);
  localparam int BW = $clog2(BookSlots);
  localparam int SW = (StopSlots > 1) ? $clog2(StopSlots) : 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SCAN   = 11'b00000000010,
    S_MKT    = 11'b00000000100,
    S_MATCH  = 11'b00000001000,
    S_EMIT   = 11'b00000010000,
    S_STOPB  = 11'b00000100000,
    S_STOPI  = 11'b00001000000,
    S_STAT   = 11'b00010000000,
    S_CANCEL = 11'b00100000000,
    S_STOPF  = 11'b01000000000,
    S_COMP   = 11'b10000000000
  } state_e;

  typedef enum logic [1:0] {
    JOB_MARKET = 2'd0,
    JOB_MATCH  = 2'd1,
    JOB_REF    = 2'd2
  } job_e;

  // Book storage, one array per side index (0 bid, 1 ask).
  logic        vld_q   [2][BookSlots];
  logic [15:0] prc_q   [2][BookSlots];
  logic [31:0] oid_q   [2][BookSlots];
  logic [23:0] qty_q   [2][BookSlots];
  logic [31:0] stm_q   [2][BookSlots];
  logic [31:0] seq_q   [2][BookSlots];
  logic        svld_q  [2][StopSlots];
  logic [31:0] sid_q   [2][StopSlots];
  logic [15:0] sprc_q  [2][StopSlots];
  logic [23:0] sqty_q  [2][StopSlots];
  logic [31:0] arrival_q;

  state_e      state_q;
  job_e        job_q;
  req_t        req_q;
  logic [1:0]  status_q;
  logic [6:0]  ntr_q;
  // Scan: walks both sides at once, one slot a cycle.
  logic [BW:0] scan_q;
  logic        bf_q [2];
  logic [BW-1:0] bi_q [2];
  // Market state.
  logic        msell_q;
  logic [31:0] mid_q;
  logic [23:0] rem_q;
  // Stop pass state.
  logic        pside_q;
  logic [15:0] ref_q;
  logic [SW:0] si_q, sk_q;
  res_t        res_q;
  logic        ovalid_q;

  logic [23:0] t_mkt, t_mat, rq, bq, aq;
  logic [BW-1:0] si;
  logic better [2];
  logic [31:0] age_i [2];
  logic [31:0] age_b [2];
  logic [BW-1:0] kopp;
  logic        stop_fire;
  logic [SW-1:0] sidx, kidx;

  assign q_ready_o   = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = res_q;
  assign si = scan_q[BW-1:0];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      age_i[s] = arrival_q - seq_q[s][si];
      age_b[s] = arrival_q - seq_q[s][bi_q[s]];
      better[s] = !bf_q[s] ||
        ((s == 1) ? (prc_q[s][si] < prc_q[s][bi_q[s]]) : (prc_q[s][si] > prc_q[s][bi_q[s]])) ||
        (prc_q[s][si] == prc_q[s][bi_q[s]] && age_i[s] > age_b[s]);
    end
  end

  assign kopp = msell_q ? bi_q[0] : bi_q[1];
  assign rq = qty_q[!msell_q][kopp];
  assign t_mkt = (rem_q < rq) ? rem_q : rq;
  assign bq = qty_q[0][bi_q[0]];
  assign aq = qty_q[1][bi_q[1]];
  assign t_mat = (bq < aq) ? bq : aq;
  assign sidx = si_q[SW-1:0];
  assign kidx = sk_q[SW-1:0];
  assign stop_fire = bf_q[!pside_q] &&
    (pside_q ? (ref_q >= sprc_q[pside_q][sidx]) : (ref_q <= sprc_q[pside_q][sidx]));

  // First free slot searches for adds.
  logic        bfree_f; logic [BW-1:0] bfree_i;
  logic        sfree_f; logic [SW-1:0] sfree_i;
  always_comb begin
    bfree_f = 1'b0; bfree_i = '0;
    for (int i = BookSlots-1; i >= 0; i--) begin
      if (!vld_q[q_data_i.side][i]) begin bfree_f = 1'b1; bfree_i = BW'(i); end
    end
    sfree_f = 1'b0; sfree_i = '0;
    for (int i = StopSlots-1; i >= 0; i--) begin
      if (!svld_q[q_data_i.side][i]) begin sfree_f = 1'b1; sfree_i = SW'(i); end
    end
  end

  logic hit;
  always_comb begin
    hit = 1'b0;
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < BookSlots; i++)
        if (vld_q[s][i] && oid_q[s][i] == req_q.ord_id) hit = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) begin
      if (q_data_i.mode == MODE_ADD_LIMIT && bfree_f && q_data_i.quantity != '0) begin
        prc_q[q_data_i.side][bfree_i] <= q_data_i.limit_price;
        oid_q[q_data_i.side][bfree_i] <= q_data_i.ord_id;
        qty_q[q_data_i.side][bfree_i] <= q_data_i.quantity;
        stm_q[q_data_i.side][bfree_i] <= q_data_i.stamp;
        seq_q[q_data_i.side][bfree_i] <= arrival_q;
      end
      if (q_data_i.mode == MODE_ADD_STOP && sfree_f && q_data_i.quantity != '0) begin
        sid_q[q_data_i.side][sfree_i]  <= q_data_i.ord_id;
        sprc_q[q_data_i.side][sfree_i] <= q_data_i.stop_price;
        sqty_q[q_data_i.side][sfree_i] <= q_data_i.quantity;
      end
    end
    if (state_q == S_MKT && (!ovalid_q || out_ready_i) && rem_q != '0 && bf_q[!msell_q])
      qty_q[!msell_q][kopp] <= rq - t_mkt;
    if (state_q == S_MATCH && (!ovalid_q || out_ready_i) && bf_q[0] && bf_q[1] &&
        prc_q[0][bi_q[0]] >= prc_q[1][bi_q[1]]) begin
      qty_q[0][bi_q[0]] <= bq - t_mat;
      qty_q[1][bi_q[1]] <= aq - t_mat;
    end
    if (state_q == S_STOPI && si_q != (SW+1)'(StopSlots) && svld_q[pside_q][sidx] &&
        !stop_fire) begin
      sid_q[pside_q][kidx]  <= sid_q[pside_q][sidx];
      sprc_q[pside_q][kidx] <= sprc_q[pside_q][sidx];
      sqty_q[pside_q][kidx] <= sqty_q[pside_q][sidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q <= JOB_MATCH;
      ovalid_q <= 1'b0;
      arrival_q <= '0;
      ntr_q <= '0;
      status_q <= ST_OK;
      scan_q <= '0;
      msell_q <= 1'b0;
      rem_q <= '0;
      pside_q <= 1'b0;
      ref_q <= '0;
      si_q <= '0;
      sk_q <= '0;
      mid_q <= '0;
      req_q <= '0;
      res_q <= '0;
      for (int s = 0; s < 2; s++) begin
        bf_q[s] <= 1'b0;
        bi_q[s] <= '0;
        for (int i = 0; i < BookSlots; i++) vld_q[s][i] <= 1'b0;
        for (int i = 0; i < StopSlots; i++) svld_q[s][i] <= 1'b0;
      end
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            req_q <= q_data_i;
            ntr_q <= '0;
            status_q <= ST_OK;
            msell_q <= q_data_i.side;
            mid_q <= q_data_i.ord_id;
            rem_q <= q_data_i.quantity;
            state_q <= S_STAT;
            unique case (q_data_i.mode)
              MODE_ADD_LIMIT: begin
                if (!bfree_f) status_q <= ST_FULL;
                else if (q_data_i.quantity != '0) begin
                  vld_q[q_data_i.side][bfree_i] <= 1'b1;
                  arrival_q <= arrival_q + 1'b1;
                end
              end
              MODE_ADD_STOP: begin
                if (!sfree_f) status_q <= ST_FULL;
                else if (q_data_i.quantity != '0) svld_q[q_data_i.side][sfree_i] <= 1'b1;
              end
              MODE_CANCEL: state_q <= S_CANCEL;
              MODE_MARKET: begin
                job_q <= JOB_MARKET; scan_q <= '0;
                bf_q[0] <= 1'b0; bf_q[1] <= 1'b0; state_q <= S_SCAN;
              end
              MODE_MATCH: begin
                job_q <= JOB_MATCH; scan_q <= '0;
                bf_q[0] <= 1'b0; bf_q[1] <= 1'b0; state_q <= S_SCAN;
              end
              MODE_CHECK: begin
                pside_q <= 1'b0; state_q <= S_STOPB;
              end
              default: ;
            endcase
          end
        end
        S_CANCEL: begin
          if (!hit) status_q <= ST_NOT_FOUND;
          for (int s = 0; s < 2; s++)
            for (int i = 0; i < BookSlots; i++)
              if (oid_q[s][i] == req_q.ord_id) vld_q[s][i] <= 1'b0;
          state_q <= S_STAT;
        end
        S_STOPB: begin
          // Sample the opposite best price before the pass starts.
          job_q <= JOB_REF; scan_q <= '0;
          bf_q[0] <= 1'b0; bf_q[1] <= 1'b0;
          si_q <= '0; sk_q <= '0;
          msell_q <= pside_q;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_q == (BW+1)'(BookSlots)) begin
            unique case (job_q)
              JOB_MARKET: state_q <= S_MKT;
              JOB_MATCH:  state_q <= S_MATCH;
              JOB_REF: begin
                if (!bf_q[!pside_q]) state_q <= S_STOPF;
                else begin
                  ref_q <= prc_q[!pside_q][bi_q[!pside_q]];
                  state_q <= S_STOPI;
                end
              end
              default: state_q <= S_STAT;
            endcase
          end else begin
            for (int s = 0; s < 2; s++)
              if (vld_q[s][si] && better[s]) begin
                bf_q[s] <= 1'b1; bi_q[s] <= si;
              end
            scan_q <= scan_q + 1'b1;
          end
        end
        S_MKT: begin
          if (rem_q == '0 || !bf_q[!msell_q]) begin
            state_q <= (req_q.mode == MODE_CHECK) ? S_COMP : S_STAT;
          end else if (!ovalid_q || out_ready_i) begin
            if (ntr_q != 7'(MaxTrades)) begin
              ovalid_q <= 1'b1;
              ntr_q <= ntr_q + 1'b1;
              res_q.kind <= KIND_TRADE;
              res_q.buyer_id   <= msell_q ? oid_q[0][kopp] : mid_q;
              res_q.seller_id  <= msell_q ? mid_q : oid_q[1][kopp];
              res_q.fill_price <= prc_q[!msell_q][kopp];
              res_q.fill_qty   <= t_mkt;
              res_q.aggressor  <= msell_q;
              res_q.status <= ST_OK;
              res_q.last <= 1'b0;
            end
            rem_q <= rem_q - t_mkt;
            if (rq == t_mkt) vld_q[!msell_q][kopp] <= 1'b0;
            job_q <= JOB_MARKET; scan_q <= '0;
            bf_q[0] <= 1'b0; bf_q[1] <= 1'b0; state_q <= S_SCAN;
          end
        end
        S_MATCH: begin
          if (!bf_q[0] || !bf_q[1] || prc_q[0][bi_q[0]] < prc_q[1][bi_q[1]]) begin
            state_q <= S_STAT;
          end else if (!ovalid_q || out_ready_i) begin
            if (ntr_q != 7'(MaxTrades)) begin
              ovalid_q <= 1'b1;
              ntr_q <= ntr_q + 1'b1;
              res_q.kind <= KIND_TRADE;
              res_q.buyer_id   <= oid_q[0][bi_q[0]];
              res_q.seller_id  <= oid_q[1][bi_q[1]];
              res_q.fill_price <= prc_q[1][bi_q[1]];
              res_q.fill_qty   <= t_mat;
              res_q.aggressor  <= (stm_q[0][bi_q[0]] > stm_q[1][bi_q[1]]) ? SIDE_BUY : SIDE_SELL;
              res_q.status <= ST_OK;
              res_q.last <= 1'b0;
            end
            if (bq == t_mat) vld_q[0][bi_q[0]] <= 1'b0;
            if (aq == t_mat) vld_q[1][bi_q[1]] <= 1'b0;
            job_q <= JOB_MATCH; scan_q <= '0;
            bf_q[0] <= 1'b0; bf_q[1] <= 1'b0; state_q <= S_SCAN;
          end
        end
        S_STOPI: begin
          // Walk the stop queue; fired stops run as market orders, the rest compact.
          if (si_q == (SW+1)'(StopSlots) || !svld_q[pside_q][sidx]) begin
            state_q <= S_STOPF;
          end else if (stop_fire) begin
            mid_q <= sid_q[pside_q][sidx];
            rem_q <= sqty_q[pside_q][sidx];
            msell_q <= pside_q;
            job_q <= JOB_MARKET; scan_q <= '0;
            bf_q[0] <= 1'b0; bf_q[1] <= 1'b0;
            state_q <= S_SCAN;
          end else begin
            si_q <= si_q + 1'b1;
            sk_q <= sk_q + 1'b1;
          end
        end
        S_COMP: begin
          // Market run of a stop finished; the opposite best is current in bf_q.
          si_q <= si_q + 1'b1;
          state_q <= S_STOPI;
        end
        S_STOPF: begin
          if (bf_q[!pside_q] || job_q != JOB_REF) begin
            for (int i = 0; i < StopSlots; i++)
              if ((SW+1)'(i) >= sk_q) svld_q[pside_q][i] <= 1'b0;
          end
          if (pside_q == SIDE_BUY) begin
            pside_q <= SIDE_SELL; state_q <= S_STOPB;
          end else begin
            state_q <= S_STAT;
          end
        end
        S_STAT: begin
          if (!ovalid_q || out_ready_i) begin
            ovalid_q <= 1'b1;
            res_q <= '0;
            res_q.kind <= KIND_STATUS;
            res_q.status <= status_q;
            res_q.last <= 1'b1;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ovalid_q || out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> ovalid_q && $stable(res_q)) else $error("result dropped");
  a_ntr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ntr_q <= 7'(MaxTrades)) else $error("trade count overflow");
  a_trade_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && res_q.kind == KIND_TRADE) |-> !res_q.last) else $error("trade flagged last");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !q_ready_o) else $error("ready while busy");
endmodule

// ===== hdl/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: request queue front end and matching engine.
// Depends on lobm_pkg, lobm_front and lobm_engine.
//
//   channel | direction | handshake              | payload
//   request | in        | in_valid_i/in_ready_o  | in_data_i  (req_t)
//   result  | out       | out_valid_o/out_ready_i| out_data_o (res_t)
//
// Adds and cancels need no book scan; market, match and stop work rescan the whole book,
// one slot a cycle, before each fill.
// Reset clears all valid bits, the arrival counter and the queue.
// The front queue keeps taking requests, until it holds two, while the engine waits on a stalled result.
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int BOOK_SLOTS = 16,
  parameter int STOP_SLOTS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);
  logic q_valid, q_ready;
  req_t q_data;

  lobm_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  lobm_engine #(.BookSlots(BOOK_SLOTS), .StopSlots(STOP_SLOTS)) u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
